### src/text_console_char_writer_assert.svh
// ----------------------------------------------------------------------------
// Text console character writer: assertion macros
// Concurrent assertion wrappers for the console blocks. Define NO_ASSERTIONS
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define TCCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("text console assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define TCCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("text console assertion failed");
`else
`define TCCW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TCCW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console character writer: package
// Geometry, field widths, character codes and the control/status types shared
// by the console modules.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;

    // Derived widths.
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int POS_W  = ROW_W + COL_W;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);

    // Field widths of the channels.
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = ATTR_W + CHAR_W;
    localparam int INDEX_W  = 11;
    localparam int OFFSET_W = 11;

    // Character codes and cell values.
    localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam int                TAB_STEP   = 8;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the incoming item, start a cell read
        logic exec;       // update the cursor, write a printable cell
        logic cnt_clr;    // clear the sweep counter
        logic cnt_step;   // advance the sweep counter
        logic fill;       // write a blank cell at the counter address
        logic fill_init;  // fill with the reset cell value
        logic scroll;     // move one cell up a row, blank the bottom row
        logic out_load;   // load the result register
        logic out_next;   // result taken from the values being computed now
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action action;
        logic    need_scroll;
        logic    fill_last;
        logic    scroll_last;
    } t_dp_stat;

endpackage

### src/tccw_if.sv
// ----------------------------------------------------------------------------
// Text console character writer: channel interfaces
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
interface tccw_in_if;
    import tccw_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;

    modport source (output valid, output action, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input action, input char_code, input cell_index,
                    output ready);
endinterface

interface tccw_out_if;
    import tccw_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] cursor_offset;
    logic [CELL_W-1:0]   cell_word;
    logic                scrolled;

    modport source (output valid, output cursor_offset, output cell_word, output scrolled,
                    input ready);
    modport sink   (input valid, input cursor_offset, input cell_word, input scrolled,
                    output ready);
endinterface

### src/tccw_ram.sv
// ----------------------------------------------------------------------------
// Text console character writer: generic RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console character writer: controller
// Sequences the reset clearing pass, item execution, screen sweeps and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tccw_pkg::t_dp_stat i_stat,
    output tccw_pkg::t_dp_cmd  o_cmd
);
    import tccw_pkg::*;

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_FILL   = 6'b001000,
        ST_SCROLL = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // The result register can take a new value when empty or being drained.
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.fill      = 1'b1;
                o_cmd.fill_init = 1'b1;
                o_cmd.cnt_step  = 1'b1;
                if (i_stat.fill_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.cnt_clr = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_stat.action == ACT_CLEAR) begin
                    n_state = ST_FILL;
                end else if (i_stat.need_scroll) begin
                    n_state = ST_SCROLL;
                end else if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_next = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_FILL: begin
                o_cmd.fill     = 1'b1;
                o_cmd.cnt_step = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_SCROLL: begin
                o_cmd.scroll   = 1'b1;
                o_cmd.cnt_step = 1'b1;
                if (i_stat.scroll_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### src/tccw_dp.sv
// ----------------------------------------------------------------------------
// Text console character writer: datapath
// Cursor, attribute, sweep counter, cell store addressing and the result
// register.
// ----------------------------------------------------------------------------
module tccw_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0]     i_cfg_wdata,
    input  logic [tccw_pkg::ACTION_W-1:0]   i_action,
    input  logic [tccw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tccw_pkg::INDEX_W-1:0]    i_cell_index,
    input  tccw_pkg::t_dp_cmd               i_cmd,
    output tccw_pkg::t_dp_stat              o_stat,
    output logic                            o_ram_we,
    output logic [tccw_pkg::ADDR_W-1:0]     o_ram_waddr,
    output logic [tccw_pkg::CELL_W-1:0]     o_ram_wdata,
    output logic                            o_ram_re,
    output logic [tccw_pkg::ADDR_W-1:0]     o_ram_raddr,
    input  logic [tccw_pkg::CELL_W-1:0]     i_ram_rdata,
    output logic [tccw_pkg::OFFSET_W-1:0]   o_cursor_offset,
    output logic [tccw_pkg::CELL_W-1:0]     o_cell_word,
    output logic                            o_scrolled
);
    import tccw_pkg::*;

    logic [ATTR_W-1:0]   r_attr;
    t_action             r_action;
    logic [CHAR_W-1:0]   r_char;
    logic                r_idx_ok;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_col;
    logic [ROW_W-1:0]    r_row;
    logic [ROW_W-1:0]    n_row;
    logic [CNT_W-1:0]    r_cnt;
    logic [CELL_W-1:0]   r_word;
    logic                r_scr;
    logic [OFFSET_W-1:0] r_out_offset;
    logic [CELL_W-1:0]   r_out_word;
    logic                r_out_scr;

    logic [COL_W:0]      w_col;
    logic [ROW_W:0]      w_row;
    logic                w_print;
    logic                w_need_scroll;
    logic                w_in_idx_ok;
    logic [CELL_W-1:0]   w_blank;
    logic [CELL_W-1:0]   w_exec_word;
    logic [POS_W-1:0]    w_put_pos;
    logic [POS_W-1:0]    w_out_pos;
    logic [COL_W-1:0]    w_sel_col;
    logic [ROW_W-1:0]    w_sel_row;
    logic [CNT_W:0]      w_src_pos;
    logic [CNT_W-1:0]    w_dst_pos;

    assign w_in_idx_ok = (32'(i_cell_index) < CELL_COUNT);
    assign w_blank     = {r_attr, BLANK_CHAR};
    assign w_exec_word = (r_action == ACT_READ && r_idx_ok) ? i_ram_rdata : '0;
    assign w_put_pos   = POS_W'(r_row) * POS_W'(COLUMNS) + POS_W'(r_col);

    // Cursor update for the item being executed, one bit wider to see wraps.
    always_comb begin
        w_col   = {1'b0, r_col};
        w_row   = {1'b0, r_row};
        w_print = 1'b0;
        if (r_action == ACT_PUT) begin
            priority if (r_char == CH_BS) begin
                if (r_col != '0) begin
                    w_col = w_col - (COL_W+1)'(1);
                end
            end else if (r_char == CH_TAB) begin
                w_col = (w_col + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
            end else if (r_char == CH_CR) begin
                w_col = '0;
            end else if (r_char == CH_LF) begin
                w_col = '0;
                w_row = w_row + (ROW_W+1)'(1);
            end else if (r_char >= BLANK_CHAR && !r_char[CHAR_W-1]) begin
                // Bytes with the top bit set are negative characters and are ignored.
                w_print = 1'b1;
                w_col   = w_col + (COL_W+1)'(1);
            end else begin
                w_col = {1'b0, r_col};
            end
            if (w_col >= (COL_W+1)'(COLUMNS)) begin
                w_col = '0;
                w_row = w_row + (ROW_W+1)'(1);
            end
        end else if (r_action == ACT_CLEAR) begin
            w_col = '0;
            w_row = '0;
        end
    end

    assign w_need_scroll = (r_action == ACT_PUT) && (w_row >= (ROW_W+1)'(ROWS));
    assign n_col = w_col[COL_W-1:0];
    assign n_row = w_need_scroll ? ROW_W'(ROWS - 1) : w_row[ROW_W-1:0];

    // Scroll sweep: read one row ahead, write the previous read one cell behind.
    assign w_src_pos = {1'b0, r_cnt} + (CNT_W+1)'(COLUMNS);
    assign w_dst_pos = r_cnt - CNT_W'(1);

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = ADDR_W'(w_put_pos);
        o_ram_wdata = {r_attr, r_char};
        o_ram_re    = 1'b0;
        o_ram_raddr = ADDR_W'(i_cell_index);
        priority if (i_cmd.fill) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = ADDR_W'(r_cnt);
            o_ram_wdata = i_cmd.fill_init ? RESET_CELL : w_blank;
        end else if (i_cmd.scroll) begin
            o_ram_we    = (r_cnt != '0);
            o_ram_waddr = ADDR_W'(w_dst_pos);
            o_ram_wdata = (w_dst_pos < CNT_W'(MOVE_COUNT)) ? i_ram_rdata : w_blank;
            o_ram_re    = (r_cnt < CNT_W'(MOVE_COUNT));
            o_ram_raddr = ADDR_W'(w_src_pos);
        end else if (i_cmd.exec) begin
            o_ram_we = w_print;
        end else if (i_cmd.accept) begin
            o_ram_re = (i_action == ACT_READ) && w_in_idx_ok;
        end else begin
            o_ram_we = 1'b0;
        end
    end

    assign w_sel_col = i_cmd.out_next ? n_col : r_col;
    assign w_sel_row = i_cmd.out_next ? n_row : r_row;
    assign w_out_pos = POS_W'(w_sel_row) * POS_W'(COLUMNS) + POS_W'(w_sel_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
            r_col  <= '0;
            r_row  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= t_action'(i_action);
            r_char   <= i_char_code;
            r_idx_ok <= w_in_idx_ok;
        end
        if (i_cmd.exec) begin
            r_word <= w_exec_word;
            r_scr  <= w_need_scroll;
        end
        if (i_cmd.out_load) begin
            r_out_offset <= OFFSET_W'(w_out_pos);
            r_out_word   <= i_cmd.out_next ? w_exec_word : r_word;
            r_out_scr    <= i_cmd.out_next ? w_need_scroll : r_scr;
        end
    end

    assign o_stat.action      = r_action;
    assign o_stat.need_scroll = w_need_scroll;
    assign o_stat.fill_last   = (r_cnt == CNT_W'(CELL_COUNT - 1));
    assign o_stat.scroll_last = (r_cnt == CNT_W'(CELL_COUNT));

    assign o_cursor_offset = r_out_offset;
    assign o_cell_word     = r_out_word;
    assign o_scrolled      = r_out_scr;

endmodule

### src/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// Text console character writer
// A text-mode console holding an 80 by 25 screen of 16-bit cells (character in
// the low byte, attribute in the high byte) and a cursor. Each request is a
// put, clear or read action and returns exactly one result with the cursor
// offset. After reset the block runs a clearing pass that fills every cell
// with 0x0F20, and ready stays low until it is done; attribute writes are
// taken at any time. For a put that does not scroll, a read and an unused
// action, the accept step presents the cell read address and the execute step
// updates the cursor, writes the cell and loads the result register, or moves
// to the done state to wait while the register is still full. A clear sweeps
// the cell store one cell per cycle; a put that scrolls moves the store up one
// row, one cell per cycle through the registered read port. One item is worked
// on at a time.
// ----------------------------------------------------------------------------
`include "text_console_char_writer_assert.svh"

module text_console_char_writer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0] i_cfg_wdata,
    tccw_in_if.sink                     i_req,
    tccw_out_if.source                  o_rsp
);
    import tccw_pkg::*;

    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic              w_in_ready;
    logic              w_out_valid;
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [CELL_W-1:0] w_ram_wdata;
    logic              w_ram_re;
    logic [ADDR_W-1:0] w_ram_raddr;
    logic [CELL_W-1:0] w_ram_rdata;
    logic              w_off_on_screen;
    logic              w_off_bottom_row;

    // The controller owns the handshakes and the sequence of each action; the
    // result register sits behind it, so a new request is taken while the
    // previous result still waits for the consumer.
    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the cursor, the attribute register and the sweep
    // counter, and drives the cell store addresses for every action.
    tccw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (i_req.action),
        .i_char_code     (i_req.char_code),
        .i_cell_index    (i_req.cell_index),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_ram_we        (w_ram_we),
        .o_ram_waddr     (w_ram_waddr),
        .o_ram_wdata     (w_ram_wdata),
        .o_ram_re        (w_ram_re),
        .o_ram_raddr     (w_ram_raddr),
        .i_ram_rdata     (w_ram_rdata),
        .o_cursor_offset (o_rsp.cursor_offset),
        .o_cell_word     (o_rsp.cell_word),
        .o_scrolled      (o_rsp.scrolled)
    );

    // The cell store: one write and one registered read per cycle.
    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

    // Where the reported cursor lies on the screen.
    assign w_off_on_screen  = (32'(o_rsp.cursor_offset) < CELL_COUNT);
    assign w_off_bottom_row = (32'(o_rsp.cursor_offset) >= MOVE_COUNT);

    // Only one item is in flight: a transfer is never followed at once by
    // another.
    `TCCW_ASSERT_NXT(a_one_item_in_flight, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)

    // The reported cursor always lies on the screen.
    `TCCW_ASSERT_IMP(a_cursor_on_screen, i_clk, i_rst_n, o_rsp.valid, w_off_on_screen)

    // After a scroll the cursor sits on the bottom row.
    `TCCW_ASSERT_IMP(a_scroll_bottom_row, i_clk, i_rst_n, o_rsp.valid && o_rsp.scrolled, w_off_bottom_row)

endmodule

### tb/tccw_console_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console character writer: result checker
// Watches the request and result channels and the attribute write port, keeps
// its own copy of the screen, cursor and attribute, and compares every result
// transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tccw_console_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0] i_cfg_wdata,
    tccw_in_if                          i_req,
    tccw_out_if                         i_rsp,
    output int unsigned                 o_fail_count,
    output int unsigned                 o_pending,
    output int unsigned                 o_checked,
    output int unsigned                 o_scrolls
);
    import tccw_pkg::*;

    localparam logic [CHAR_W-1:0] LAST_PRINTABLE = 8'h7F;

    typedef struct packed {
        logic [OFFSET_W-1:0] cursor_offset;
        logic [CELL_W-1:0]   cell_word;
        logic                scrolled;
    } t_console_result;

    logic [CELL_W-1:0] screen_cells [CELL_COUNT];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [ATTR_W-1:0] attribute;

    t_console_result   pending_results [$];
    t_console_result   predicted;
    t_console_result   observed;
    int unsigned       fail_count = 0;
    int unsigned       checked_count = 0;
    int unsigned       scroll_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_scrolls    = 0;
    end

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Updates the screen copy for one accepted request and returns the result
    // the block must give for it.
    task automatic apply_console_action(input t_action act, input logic [CHAR_W-1:0] code,
                                        input logic [INDEX_W-1:0] index,
                                        output t_console_result res);
        int unsigned pos;
        res = '0;
        case (act)
            ACT_PUT: begin
                if (code == CH_BS) begin
                    if (cur_col != 0) cur_col--;
                end else if (code == CH_TAB) begin
                    cur_col = COL_W'((int'(cur_col) + TAB_STEP) / TAB_STEP * TAB_STEP);
                end else if (code == CH_CR) begin
                    cur_col = '0;
                end else if (code == CH_LF) begin
                    cur_col = '0;
                    cur_row++;
                end else if (code >= BLANK_CHAR && code <= LAST_PRINTABLE) begin
                    pos = int'(cur_row) * COLUMNS + int'(cur_col);
                    if (pos < CELL_COUNT) screen_cells[pos] = {attribute, code};
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = '0;
                    cur_row++;
                end
                // Falling off the bottom moves everything up one row.
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < MOVE_COUNT; i++)
                        screen_cells[i] = screen_cells[i + COLUMNS];
                    for (int i = MOVE_COUNT; i < CELL_COUNT; i++)
                        screen_cells[i] = {attribute, BLANK_CHAR};
                    cur_row      = ROW_W'(ROWS - 1);
                    res.scrolled = 1'b1;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = {attribute, BLANK_CHAR};
                cur_col = '0;
                cur_row = '0;
            end
            ACT_READ: begin
                if (index < CELL_COUNT) res.cell_word = screen_cells[index];
            end
            default: ;
        endcase
        res.cursor_offset = OFFSET_W'(int'(cur_row) * COLUMNS + int'(cur_col));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = RESET_CELL;
            cur_col   = '0;
            cur_row   = '0;
            attribute = ATTR_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_we) attribute = i_cfg_wdata;
            if (i_req.valid && i_req.ready) begin
                apply_console_action(t_action'(i_req.action), i_req.char_code, i_req.cell_index,
                                     predicted);
                pending_results.push_back(predicted);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                observed = '{i_rsp.cursor_offset, i_rsp.cell_word, i_rsp.scrolled};
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no request outstanding",
                                    observed.cursor_offset, 0);
                end else begin
                    predicted = pending_results.pop_front();
                    checked_count++;
                    if (predicted.scrolled) scroll_count++;
                    if (observed.cursor_offset !== predicted.cursor_offset)
                        report_mismatch("cursor_offset", observed.cursor_offset,
                                        predicted.cursor_offset);
                    if (observed.cell_word !== predicted.cell_word)
                        report_mismatch("cell_word", observed.cell_word, predicted.cell_word);
                    if (observed.scrolled !== predicted.scrolled)
                        report_mismatch("scrolled", observed.scrolled, predicted.scrolled);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_results.size();
        o_checked    <= checked_count;
        o_scrolls    <= scroll_count;
    end

endmodule

### tb/tb_text_console_char_writer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console character writer: testbench
// Drives put, clear and read requests into the console with random idle gaps
// on both channels, changes the text attribute between phases, and lets the
// checker beside the block predict and compare every result.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer;
    import tccw_pkg::*;

    // Requests per random phase that actually do something; one phase per
    // attribute setting below.
    localparam int unsigned PHASE_ITEMS = 200;
    // A clear or a scroll keeps the block busy for a whole sweep of the screen. Even if
    // every request were one of those and every transfer saw the longest idle
    // gap on both sides, 1600 requests would fit in well under this limit.
    localparam longint unsigned LIMIT_CYCLES = 12_000_000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_wdata;

    tccw_in_if  req_if ();
    tccw_out_if rsp_if ();

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned checked_count;
    int unsigned scroll_count;

    // When set, neither side inserts idle cycles.
    logic            no_idle;
    int unsigned     ready_hold;
    longint unsigned cycle_count;

    // Counts of requests by action, and of those that change or report state.
    int unsigned n_put, n_clear, n_read, n_other, n_useful, n_attr;

    text_console_char_writer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    tccw_console_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count),
        .o_scrolls    (scroll_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Idle gap length: usually none, often a few cycles, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // The result side holds ready low for random stretches. A stall may land
    // while the block is mid-sweep or right as a result comes out; either way
    // the result must stay put until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            ready_hold   <= 0;
        end else if (no_idle) begin
            rsp_if.ready <= 1'b1;
            ready_hold   <= 0;
        end else if (ready_hold != 0) begin
            rsp_if.ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
        end
    end

    // Hang guard: a lost result or a block stuck busy ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("run stopped at cycle %0d with %0d results still outstanding",
                     cycle_count, pending_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one request and returns at the clock edge of its transfer. Valid
    // stays high on return, so back-to-back requests keep it high; it only
    // drops when an idle gap is taken.
    task automatic send_request(t_action act, logic [CHAR_W-1:0] code,
                                logic [INDEX_W-1:0] index);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.char_code  <= code;
        req_if.cell_index <= index;
        do @(posedge i_clk); while (!req_if.ready);
        case (act)
            ACT_PUT:   n_put++;
            ACT_CLEAR: n_clear++;
            ACT_READ:  n_read++;
            default:   n_other++;
        endcase
        // Unused action codes, stray control bytes and bytes with the top bit
        // set leave the console untouched, so they do not count as work.
        if (!(act == ACT_NONE || (act == ACT_PUT && (code >= 8'h80 ||
              (code < BLANK_CHAR && code != CH_BS && code != CH_TAB &&
               code != CH_CR && code != CH_LF)))))
            n_useful++;
    endtask

    // The attribute is only changed once every result is back, so that no
    // request is in flight when the new value takes hold.
    task automatic write_attribute(logic [ATTR_W-1:0] value);
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        n_attr++;
    endtask

    // Random traffic shaped like console output: lines of text ended by a
    // newline, runs of cursor controls, reads scattered over the screen, and
    // a little noise. Once the cursor reaches the bottom row every newline and
    // every line wrap scrolls, so reads afterwards see moved rows.
    task automatic run_random(int unsigned target, bit quiet);
        int unsigned start, kind, len, r;
        logic [CHAR_W-1:0] code;
        start = n_useful;
        while (n_useful - start < target) begin
            // Some segments run with no idle cycles at all.
            no_idle <= quiet || ($urandom_range(0, 9) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                // A line of text, now and then long enough to wrap.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
                repeat (len) begin
                    send_request(ACT_PUT, CHAR_W'($urandom_range(BLANK_CHAR, 8'h7F)), '0);
                    if ($urandom_range(0, 9) == 0)
                        send_request(ACT_READ, '0, INDEX_W'($urandom_range(0, CELL_COUNT - 1)));
                end
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    send_request(ACT_PUT, CH_LF, '0);
                end else if (r < 85) begin
                    send_request(ACT_PUT, CH_CR, '0);
                    send_request(ACT_PUT, CH_LF, '0);
                end
            end else if (kind < 70) begin
                // Cursor movement: tabs (which may wrap), backspaces, returns, mixed with printable characters.
                repeat ($urandom_range(1, 12)) begin
                    r = $urandom_range(0, 9);
                    if (r < 4)      code = CH_TAB;
                    else if (r < 7) code = CH_BS;
                    else if (r < 8) code = CH_CR;
                    else            code = CHAR_W'($urandom_range(BLANK_CHAR, 8'h7F));
                    send_request(ACT_PUT, code, '0);
                end
            end else if (kind < 85) begin
                // Reads, mostly on screen, some near and past the last cell.
                repeat ($urandom_range(1, 4)) begin
                    r = $urandom_range(0, 9);
                    if (r < 7)
                        send_request(ACT_READ, '0, INDEX_W'($urandom_range(0, CELL_COUNT - 1)));
                    else if (r < 9)
                        send_request(ACT_READ, '0, INDEX_W'($urandom_range(1920, 2047)));
                    else
                        send_request(ACT_READ, '0, INDEX_W'($urandom_range(0, 2047)));
                end
            end else if (kind < 97) begin
                // Noise: any action code with any byte and any index.
                repeat ($urandom_range(1, 5))
                    send_request(t_action'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                                 INDEX_W'($urandom_range(0, 2047)));
            end else begin
                send_request(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)),
                             INDEX_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    initial begin
        logic [ATTR_W-1:0] phase_attr [7];

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        req_if.valid      = 1'b0;
        req_if.action     = '0;
        req_if.char_code  = '0;
        req_if.cell_index = '0;
        rsp_if.ready      = 1'b0;
        no_idle           = 1'b0;
        ready_hold        = 0;
        cycle_count       = 0;
        n_put = 0; n_clear = 0; n_read = 0; n_other = 0; n_useful = 0; n_attr = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the attribute still at its reset value. The
        // block runs its clearing pass first; the first transfer simply waits
        // for ready.
        send_request(ACT_PUT, 8'h41, '0);        // ordinary character
        send_request(ACT_PUT, BLANK_CHAR, '0);   // lowest printable byte
        send_request(ACT_PUT, 8'h7F, '0);        // highest printable byte
        send_request(ACT_PUT, 8'h1F, '0);        // stray control bytes do nothing
        send_request(ACT_PUT, 8'h00, '0);
        send_request(ACT_PUT, 8'h80, '0);        // top bit set: nothing written
        send_request(ACT_PUT, 8'hFF, '0);
        send_request(ACT_PUT, CH_BS, '0);        // moves left, must not erase
        send_request(ACT_PUT, CH_CR, '0);
        send_request(ACT_PUT, CH_BS, '0);        // backspace at column 0 stays
        send_request(ACT_READ, '0, 11'd0);
        send_request(ACT_READ, '0, 11'd2);       // cell passed over by backspace
        send_request(ACT_READ, '0, 11'd1999);    // last cell on screen
        send_request(ACT_READ, '0, 11'd2047);    // off screen reads as zero
        send_request(ACT_NONE, 8'hFF, 11'h7FF);  // unused action code
        // Ten tabs from column 0: the last one reaches the right edge and wraps.
        repeat (10) send_request(ACT_PUT, CH_TAB, '0);
        send_request(ACT_PUT, CH_LF, '0);
        send_request(ACT_CLEAR, '0, '0);

        // Random phases, each under its own attribute; both extremes included.
        phase_attr[0] = 8'h00;
        phase_attr[1] = 8'hFF;
        phase_attr[2] = 8'h1F;
        phase_attr[3] = ATTR_W'($urandom_range(0, 255));
        phase_attr[4] = 8'h70;
        phase_attr[5] = ATTR_W'($urandom_range(0, 255));
        phase_attr[6] = 8'hA5;
        for (int p = 0; p < 7; p++) begin
            write_attribute(phase_attr[p]);
            run_random(PHASE_ITEMS, p == 4);
        end

        // Drain: wait for every outstanding result, then a short settle.
        req_if.valid <= 1'b0;
        no_idle      <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (20) @(posedge i_clk);

        $display("covered %0d requests: %0d puts, %0d clears, %0d reads, %0d unused actions",
                 n_put + n_clear + n_read + n_other, n_put, n_clear, n_read, n_other);
        $display("%0d results compared, %0d with a scroll, over %0d attribute settings",
                 checked_count, scroll_count, n_attr);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
